@@ hdl/sensor_health_classifier_macros.svh @@
// Assertion macros shared by the sensor health classifier checkers.
// The macros expect signals named clk and rst in the scope that uses them.
`ifndef SENSOR_HEALTH_CLASSIFIER_MACROS_SVH
`define SENSOR_HEALTH_CLASSIFIER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SHC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define SHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define SHC_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/shc_pkg.sv @@
// Package of types and constants for the sensor health classifier.
package shc_pkg;

  localparam int TIME_BITS = 40;
  localparam int NSRC      = 3;
  localparam int FLAG_W    = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // Commands
  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_EVAL  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Sources
  localparam logic [1:0] SRC_IMU    = 2'd0;
  localparam logic [1:0] SRC_THRUST = 2'd1;
  localparam logic [1:0] SRC_ALT    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALTITUDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRUST_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRUST_CEILING = 3'd4;

  // Configuration reset values
  localparam logic [31:0]        RST_SAMPLE_TIMEOUT = 32'd500000;
  localparam logic [29:0]        RST_MAX_PERIOD     = 30'd0;
  localparam logic signed [31:0] RST_MIN_ALTITUDE   = 32'sd0;
  localparam logic signed [31:0] RST_THRUST_FLOOR   = 32'sd0;
  localparam logic signed [31:0] RST_THRUST_CEILING = 32'sd65536;

  // Timing limits
  localparam int unsigned        JUMP_US       = 50000;
  localparam logic signed [31:0] JUMP_NEG_US   = -32'sd50000;
  localparam logic [29:0]        PERIOD_CAP_US = 30'd1000000000;

  // Flag bit positions
  localparam int FLAG_IMU_MISSING    = 0;
  localparam int FLAG_THRUST_MISSING = 1;
  localparam int FLAG_ALT_MISSING    = 2;
  localparam int FLAG_TIME_JUMP      = 3;
  localparam int FLAG_IMU_STALE      = 4;
  localparam int FLAG_THRUST_STALE   = 5;
  localparam int FLAG_ALT_STALE      = 6;
  localparam int FLAG_RATE_LOW       = 7;
  localparam int FLAG_IMU_INVALID    = 8;
  localparam int FLAG_THRUST_INVALID = 9;
  localparam int FLAG_ALT_INVALID    = 10;
  localparam int FLAG_BELOW_ALT      = 11;
  localparam int FLAG_GROUND_HOLD    = 12;
  localparam int FLAG_SM_FAULT       = 13;

  typedef enum logic [1:0] {
    HS_SELF_CHECK = 2'd0,
    HS_GROUND     = 2'd1,
    HS_AIRBORNE   = 2'd2,
    HS_FAULT      = 2'd3
  } hstate_t;

endpackage

@@ hdl/shc_sample_if.sv @@
// Input channel interface: one command beat per handshake.
interface shc_sample_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [1:0]                     source_id;
  logic [shc_pkg::TIME_BITS-1:0]  sample_stamp_us;
  logic signed [31:0]             sample_period_us;
  logic signed [31:0]             sample_value;
  logic                           sample_finite;
  logic [shc_pkg::TIME_BITS-1:0]  now_us;
  logic                           fault_requested;
  logic                           thrust_masked;
  logic [1:0]                     est_state;

  modport source (
    output valid, cmd, source_id, sample_stamp_us, sample_period_us, sample_value,
           sample_finite, now_us, fault_requested, thrust_masked, est_state,
    input  ready
  );
  modport sink (
    input  valid, cmd, source_id, sample_stamp_us, sample_period_us, sample_value,
           sample_finite, now_us, fault_requested, thrust_masked, est_state,
    output ready
  );
endinterface

@@ hdl/shc_result_if.sv @@
// Result channel interface: one health result beat per handshake.
interface shc_result_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          health_state;
  logic [shc_pkg::FLAG_W-1:0]          health_flags;
  logic                                ready_res;
  logic [shc_pkg::TIME_BITS-1:0]       source_stamp_us;
  logic                                post_transition;

  modport source (
    output valid, health_state, health_flags, ready_res, source_stamp_us,
           post_transition,
    input  ready
  );
  modport sink (
    input  valid, health_state, health_flags, ready_res, source_stamp_us,
           post_transition,
    output ready
  );
endinterface

@@ hdl/shc_cfg_if.sv @@
// Configuration write channel interface: register index and data per beat.
interface shc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [shc_pkg::CFG_IDX_W-1:0]    index;
  logic [shc_pkg::CFG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/sensor_health_classifier.sv @@
// Top level of the sensor health classifier: sample store and health classification.
//
//  channel  | role   | beat contents
//  ---------+--------+-----------------------------------------------------------
//  sample   | sink   | cmd, source, stamp, period, value, finite, now, requests
//  result   | source | health state, flags, ready, thrust stamp, transition request
//  cfg      | sink   | register index and 32-bit write data, always ready
//
// An accepted beat loads the input register; from there the item passes through the
// classification logic into the result register, which drives the result beat. A new
// item is accepted every cycle unless a stalled result holds the input register; the
// 40-bit stamp subtract-and-compare per source sets the clock period. Store and
// unknown commands leave no result beat.
// Reset (synchronous, active high) empties both registers, forgets every stored
// sample and restores the register defaults. A stalled result holds an evaluate or
// tick item in the input register, dropping sample ready until the beat is taken.
module sensor_health_classifier (
  input  logic              clk,
  input  logic              rst,
  shc_sample_if.sink        sample,
  shc_result_if.source      result,
  shc_cfg_if.sink           cfg
);

  localparam int TB = shc_pkg::TIME_BITS;
  localparam int FW = shc_pkg::FLAG_W;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [1:0]          source_id;
    logic [TB-1:0]       sample_stamp_us;
    logic signed [31:0]  sample_period_us;
    logic signed [31:0]  sample_value;
    logic                sample_finite;
    logic [TB-1:0]       now_us;
    logic                fault_requested;
    logic                thrust_masked;
    logic [1:0]          est_state;
  } item_t;

  // Configuration registers
  logic [31:0]        sample_timeout_us;
  logic [29:0]        max_period_us;
  logic signed [31:0] min_altitude_mm;
  logic signed [31:0] thrust_floor_q16;
  logic signed [31:0] thrust_ceiling_q16;

  // Per-source sample store
  logic               src_received [shc_pkg::NSRC];
  logic               src_finite   [shc_pkg::NSRC];
  logic [TB-1:0]      src_stamp    [shc_pkg::NSRC];
  logic signed [31:0] src_period   [shc_pkg::NSRC];
  logic signed [31:0] src_value    [shc_pkg::NSRC];

  // Input register
  logic  s1_valid;
  item_t s1;
  logic  s1_emits;
  logic  s1_adv;

  // Result register
  logic                  res_valid;
  shc_pkg::hstate_t      res_state;
  logic [FW-1:0]         res_flags;
  logic                  res_ready;
  logic [TB-1:0]         res_stamp;
  logic                  res_post;

  // Classification outputs
  shc_pkg::hstate_t      cls_state;
  logic [FW-1:0]         cls_flags;
  logic                  cls_ready;
  logic [TB-1:0]         cls_stamp;

  logic [shc_pkg::NSRC-1:0] ahead;
  logic [shc_pkg::NSRC-1:0] jump;
  logic [shc_pkg::NSRC-1:0] stale;
  logic [shc_pkg::NSRC-1:0] rate_low;
  logic [TB-1:0]            lead   [shc_pkg::NSRC];
  logic [TB-1:0]            age    [shc_pkg::NSRC];
  logic [29:0]              lim_cap;

  // ---------------------------------------------------------------------------
  // Configuration writes: always ready, unknown indexes dropped.
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_timeout_us  <= shc_pkg::RST_SAMPLE_TIMEOUT;
      max_period_us      <= shc_pkg::RST_MAX_PERIOD;
      min_altitude_mm    <= shc_pkg::RST_MIN_ALTITUDE;
      thrust_floor_q16   <= shc_pkg::RST_THRUST_FLOOR;
      thrust_ceiling_q16 <= shc_pkg::RST_THRUST_CEILING;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        shc_pkg::CFG_SAMPLE_TIMEOUT: sample_timeout_us  <= cfg.data;
        shc_pkg::CFG_MAX_PERIOD:     max_period_us      <= cfg.data[29:0];
        shc_pkg::CFG_MIN_ALTITUDE:   min_altitude_mm    <= $signed(cfg.data);
        shc_pkg::CFG_THRUST_FLOOR:   thrust_floor_q16   <= $signed(cfg.data);
        shc_pkg::CFG_THRUST_CEILING: thrust_ceiling_q16 <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The input register advances unless it holds a result-producing
  // item while the result register is full and stalled.
  // ---------------------------------------------------------------------------
  assign s1_emits = (s1.cmd == shc_pkg::CMD_EVAL) || (s1.cmd == shc_pkg::CMD_TICK);
  assign s1_adv   = s1_valid && (!s1_emits || !res_valid || result.ready);
  assign sample.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  // Capture the beat into the input register.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1.cmd              <= sample.cmd;
      s1.source_id        <= sample.source_id;
      s1.sample_stamp_us  <= sample.sample_stamp_us;
      s1.sample_period_us <= sample.sample_period_us;
      s1.sample_value     <= sample.sample_value;
      s1.sample_finite    <= sample.sample_finite;
      s1.now_us           <= sample.now_us;
      s1.fault_requested  <= sample.fault_requested;
      s1.thrust_masked    <= sample.thrust_masked;
      s1.est_state        <= sample.est_state;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample store. Stores land as the item leaves the input register, so the
  // next item in order already sees them. Source code three is dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < shc_pkg::NSRC; i++) begin
        src_received[i] <= 1'b0;
        src_finite[i]   <= 1'b0;
      end
    end else if (s1_adv && s1.cmd == shc_pkg::CMD_STORE &&
                 s1.source_id < 2'(shc_pkg::NSRC)) begin
      src_received[s1.source_id] <= 1'b1;
      src_finite[s1.source_id]   <= s1.sample_finite;
    end
  end

  // Sample payload is only read once its source has been received.
  always_ff @(posedge clk) begin
    if (s1_adv && s1.cmd == shc_pkg::CMD_STORE &&
        s1.source_id < 2'(shc_pkg::NSRC)) begin
      src_stamp[s1.source_id]  <= s1.sample_stamp_us;
      src_period[s1.source_id] <= s1.sample_period_us;
      src_value[s1.source_id]  <= s1.sample_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-source checks, all sources side by side.
  // ---------------------------------------------------------------------------
  assign lim_cap = (max_period_us > shc_pkg::PERIOD_CAP_US) ? shc_pkg::PERIOD_CAP_US
                                                            : max_period_us;

  always_comb begin
    for (int i = 0; i < shc_pkg::NSRC; i++) begin
      ahead[i] = src_stamp[i] > s1.now_us;
      lead[i]  = src_stamp[i] - s1.now_us;
      age[i]   = s1.now_us - src_stamp[i];
      // Stamp far in the future or a strongly negative period
      jump[i]  = (ahead[i] && (lead[i] > TB'(shc_pkg::JUMP_US))) ||
                 (src_period[i] < shc_pkg::JUMP_NEG_US);
      // A stamp later than now is never stale
      stale[i] = !ahead[i] && (age[i] > TB'(sample_timeout_us));
      // Zero limit turns the rate test off; non-positive periods never trip it
      rate_low[i] = (max_period_us != 30'd0) && src_received[i] &&
                    (src_period[i] > 32'sd0) &&
                    ($unsigned(src_period[i]) > 32'(lim_cap));
    end
  end

  // ---------------------------------------------------------------------------
  // Priority classification: the first group that fires decides the result.
  // ---------------------------------------------------------------------------
  always_comb begin
    cls_state = shc_pkg::HS_SELF_CHECK;
    cls_flags = '0;
    cls_ready = 1'b0;
    cls_stamp = '0;
    if (s1.fault_requested) begin
      cls_state = shc_pkg::HS_FAULT;
      cls_flags[shc_pkg::FLAG_SM_FAULT] = 1'b1;
    end else if (!src_received[shc_pkg::SRC_IMU] || !src_received[shc_pkg::SRC_THRUST] ||
                 !src_received[shc_pkg::SRC_ALT]) begin
      cls_flags[shc_pkg::FLAG_IMU_MISSING]    = !src_received[shc_pkg::SRC_IMU];
      cls_flags[shc_pkg::FLAG_THRUST_MISSING] = !src_received[shc_pkg::SRC_THRUST];
      cls_flags[shc_pkg::FLAG_ALT_MISSING]    = !src_received[shc_pkg::SRC_ALT];
    end else if (|jump) begin
      cls_flags[shc_pkg::FLAG_TIME_JUMP] = 1'b1;
    end else if ((|stale) || (|rate_low)) begin
      cls_flags[shc_pkg::FLAG_IMU_STALE]    = stale[shc_pkg::SRC_IMU];
      cls_flags[shc_pkg::FLAG_THRUST_STALE] = stale[shc_pkg::SRC_THRUST];
      cls_flags[shc_pkg::FLAG_ALT_STALE]    = stale[shc_pkg::SRC_ALT];
      cls_flags[shc_pkg::FLAG_RATE_LOW]     = |rate_low;
    end else if (!src_finite[shc_pkg::SRC_IMU] || !src_finite[shc_pkg::SRC_ALT] ||
                 s1.thrust_masked || !src_finite[shc_pkg::SRC_THRUST] ||
                 (src_value[shc_pkg::SRC_THRUST] <= thrust_floor_q16) ||
                 (src_value[shc_pkg::SRC_THRUST] > thrust_ceiling_q16)) begin
      cls_flags[shc_pkg::FLAG_IMU_INVALID]    = !src_finite[shc_pkg::SRC_IMU];
      cls_flags[shc_pkg::FLAG_ALT_INVALID]    = !src_finite[shc_pkg::SRC_ALT];
      cls_flags[shc_pkg::FLAG_THRUST_INVALID] =
        s1.thrust_masked || !src_finite[shc_pkg::SRC_THRUST] ||
        (src_value[shc_pkg::SRC_THRUST] <= thrust_floor_q16) ||
        (src_value[shc_pkg::SRC_THRUST] > thrust_ceiling_q16);
    end else if (src_value[shc_pkg::SRC_ALT] < min_altitude_mm) begin
      // Below minimum altitude: hold on ground
      cls_state = shc_pkg::HS_GROUND;
      cls_flags[shc_pkg::FLAG_BELOW_ALT]   = 1'b1;
      cls_flags[shc_pkg::FLAG_GROUND_HOLD] = 1'b1;
    end else begin
      cls_state = shc_pkg::HS_AIRBORNE;
      cls_ready = 1'b1;
      cls_stamp = src_stamp[shc_pkg::SRC_THRUST];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on a result-producing advance, clear once taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_emits) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emits) begin
      res_state <= cls_state;
      res_flags <= cls_flags;
      res_ready <= cls_ready;
      res_stamp <= cls_stamp;
      // Request a transition only on evaluate
      res_post  <= (s1.cmd == shc_pkg::CMD_EVAL) && (cls_state != s1.est_state);
    end
  end

  assign result.valid           = res_valid;
  assign result.health_state    = res_state;
  assign result.health_flags    = res_flags;
  assign result.ready_res       = res_ready;
  assign result.source_stamp_us = res_stamp;
  assign result.post_transition = res_post;

endmodule

@@ hdl/shc_checker.sv @@
// Port-level checker for the sensor health classifier, with its bind.
`include "sensor_health_classifier_macros.svh"

module shc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    health_state,
  input logic [shc_pkg::FLAG_W-1:0]    health_flags,
  input logic                          ready_res,
  input logic [shc_pkg::TIME_BITS-1:0] source_stamp_us,
  input logic                          post_transition
);

  `SHC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable({health_state, health_flags, ready_res, source_stamp_us, post_transition}), "stalled result beat changed")
  `SHC_ASSERT_IMPLY(a_ready_airborne, out_valid && ready_res, health_state == shc_pkg::HS_AIRBORNE && health_flags == '0, "ready without clean airborne state")
  `SHC_ASSERT_IMPLY(a_stamp_zero, out_valid && !ready_res, source_stamp_us == '0, "thrust stamp shown while not ready")
  `SHC_ASSERT_IMPLY(a_fault_flag, out_valid && health_state == shc_pkg::HS_FAULT, health_flags == (shc_pkg::FLAG_W'(1) << shc_pkg::FLAG_SM_FAULT), "fault state with wrong flags")
  `SHC_ASSERT_RESET(a_reset_empty, rst, !out_valid, "result valid after reset")

endmodule

bind sensor_health_classifier shc_checker u_shc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .health_state    (result.health_state),
  .health_flags    (result.health_flags),
  .ready_res       (result.ready_res),
  .source_stamp_us (result.source_stamp_us),
  .post_transition (result.post_transition)
);
